### rtl/core/aarm_pkg.sv
// ----------------------------------------------------------------------------
// aarm_pkg
// Shared types, constants and tables for the axis-angle rotation matrix
// pipeline.
// ----------------------------------------------------------------------------
package aarm_pkg;

   localparam int unsigned DEF_CORDIC_STEPS  = 16;
   localparam int unsigned DEF_FRACTION_BITS = 14;

   localparam int unsigned FIELD_W      = 16;
   localparam int unsigned CORDIC_W     = 34;
   localparam int unsigned ANGLE_FRAC   = 30;
   localparam int unsigned ATAN_ENTRIES = 24;
   localparam int unsigned ANGLE_PIPE   = 6;
   localparam int unsigned MATRIX_PIPE  = 5;

   // angle reduction, 1/64 degree units
   localparam int TURN_UNITS    = 23040;
   localparam int QUARTER_UNITS = 5760;
   localparam int unsigned RED_W = 15;
   localparam int unsigned REM_W = 13;

   // radians = rem * (RAD_INT + RAD_FRAC2 / RAD_DIV) rounded, in Q30
   localparam int unsigned BASE_W      = 32;
   localparam int unsigned NUM_W       = 35;
   localparam int unsigned NUM_SHIFT   = 22;
   localparam int unsigned RECIP_W     = 16;
   localparam int unsigned QEST_W      = NUM_W - NUM_SHIFT;
   localparam int unsigned QMUL_W      = QEST_W + RECIP_W;
   localparam logic [18:0] RAD_INT     = 19'd292817;
   localparam logic [22:0] RAD_FRAC2   = 23'd4595086;
   localparam logic [21:0] RAD_HALF    = 22'd3515625;
   localparam logic [22:0] RAD_DIV     = 23'd7031250;
   localparam logic [RECIP_W-1:0] RAD_RECIP = 16'd39093;

   localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic signed [CORDIC_W-1:0] ONE_Q30     = 34'sd1073741824;

   typedef struct packed {
      logic [1:0]                quad;
      logic signed [FIELD_W-1:0] axis_x;
      logic signed [FIELD_W-1:0] axis_y;
      logic signed [FIELD_W-1:0] axis_z;
   } side_type;

   function automatic logic [30:0] atan_q30(input int unsigned idx);
      logic [30:0] val;
      unique case (idx)
         0:       val = 31'd843314856;
         1:       val = 31'd497837829;
         2:       val = 31'd263043836;
         3:       val = 31'd133525158;
         4:       val = 31'd67021686;
         5:       val = 31'd33543515;
         6:       val = 31'd16775850;
         7:       val = 31'd8388437;
         8:       val = 31'd4194282;
         9:       val = 31'd2097149;
         10:      val = 31'd1048575;
         11:      val = 31'd524287;
         12:      val = 31'd262143;
         13:      val = 31'd131071;
         14:      val = 31'd65535;
         15:      val = 31'd32767;
         16:      val = 31'd16383;
         17:      val = 31'd8191;
         18:      val = 31'd4095;
         19:      val = 31'd2047;
         20:      val = 31'd1023;
         21:      val = 31'd511;
         22:      val = 31'd255;
         23:      val = 31'd127;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

### rtl/core/aarm_angle.sv
// ----------------------------------------------------------------------------
// aarm_angle
// Reduces the angle to one turn, splits off the quadrant and converts the
// remainder to Q30 radians by constant multiply with reciprocal correction.
// ----------------------------------------------------------------------------
module aarm_angle
   import aarm_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  logic signed [FIELD_W-1:0]  in_angle,
   input  side_type                   in_side,
   output logic                       out_valid,
   output logic signed [CORDIC_W-1:0] out_theta,
   output side_type                   out_side
);

   logic [ANGLE_PIPE-1:0] v_ff;
   side_type              side_ff [ANGLE_PIPE];

   logic signed [16:0]  ang_ext;
   logic signed [16:0]  wrap;
   logic [RED_W-1:0]    red_in, red_ff;
   logic [REM_W-1:0]    rem_in, rem_ff;
   logic [1:0]          quad_in;
   logic [BASE_W-1:0]   base_in, base_a_ff, base_b_ff, base_c_ff;
   logic [NUM_W-1:0]    num_in, num_a_ff, num_b_ff, num_c_ff;
   logic [QMUL_W-1:0]   qmul;
   logic [QEST_W-1:0]   qest_in, qest_ff, qest_b_ff;
   logic [NUM_W-1:0]    prod_in, prod_ff;
   logic [NUM_W-1:0]    rmd;
   logic [QEST_W-1:0]   q;
   logic [BASE_W-1:0]   rad_in, rad_ff;

   always_comb begin
      ang_ext = 17'(in_angle);
      wrap    = ang_ext[16] ? ang_ext + 17'(TURN_UNITS) : ang_ext;
      priority if (wrap < 17'sd0) begin
         red_in = RED_W'(wrap + 17'(TURN_UNITS));
      end else if (wrap >= 17'(TURN_UNITS)) begin
         red_in = RED_W'(wrap - 17'(TURN_UNITS));
      end else begin
         red_in = RED_W'(wrap);
      end
   end

   always_comb begin
      priority if (red_ff >= RED_W'(3 * QUARTER_UNITS)) begin
         quad_in = 2'd3;
         rem_in  = REM_W'(red_ff - RED_W'(3 * QUARTER_UNITS));
      end else if (red_ff >= RED_W'(2 * QUARTER_UNITS)) begin
         quad_in = 2'd2;
         rem_in  = REM_W'(red_ff - RED_W'(2 * QUARTER_UNITS));
      end else if (red_ff >= RED_W'(QUARTER_UNITS)) begin
         quad_in = 2'd1;
         rem_in  = REM_W'(red_ff - RED_W'(QUARTER_UNITS));
      end else begin
         quad_in = 2'd0;
         rem_in  = REM_W'(red_ff);
      end
   end

   always_comb begin
      base_in = BASE_W'(rem_ff) * BASE_W'(RAD_INT);
      num_in  = NUM_W'(rem_ff) * NUM_W'(RAD_FRAC2) + NUM_W'(RAD_HALF);
      qmul    = QMUL_W'(num_a_ff[NUM_W-1:NUM_SHIFT]) * QMUL_W'(RAD_RECIP);
      qest_in = qmul[QMUL_W-1:RECIP_W];
      prod_in = NUM_W'(qest_ff) * NUM_W'(RAD_DIV);
      rmd     = num_c_ff - prod_ff;
      q       = qest_b_ff + QEST_W'(rmd >= NUM_W'(RAD_DIV));
      rad_in  = base_c_ff + BASE_W'(q);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[ANGLE_PIPE-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      red_ff     <= red_in;
      side_ff[0] <= in_side;
      rem_ff     <= rem_in;
      side_ff[1] <= '{quad: quad_in, axis_x: side_ff[0].axis_x,
                      axis_y: side_ff[0].axis_y, axis_z: side_ff[0].axis_z};
      base_a_ff  <= base_in;
      num_a_ff   <= num_in;
      side_ff[2] <= side_ff[1];
      base_b_ff  <= base_a_ff;
      num_b_ff   <= num_a_ff;
      side_ff[3] <= side_ff[2];
      qest_ff    <= qest_in;
      base_c_ff  <= base_b_ff;
      num_c_ff   <= num_b_ff;
      qest_b_ff  <= qest_ff;
      prod_ff    <= prod_in;
      side_ff[4] <= side_ff[3];
      rad_ff     <= rad_in;
      side_ff[5] <= side_ff[4];
   end

   assign out_valid = v_ff[ANGLE_PIPE-1];
   assign out_theta = CORDIC_W'(rad_ff);
   assign out_side  = side_ff[ANGLE_PIPE-1];

`ifndef SYNTH
   a_rem_in_quarter: assert property (@(posedge clock) disable iff (reset)
      v_ff[1] |-> (rem_ff < REM_W'(QUARTER_UNITS)))
      else $error("angle remainder not below a quarter turn");

   a_recip_within_one: assert property (@(posedge clock) disable iff (reset)
      v_ff[4] |-> (rmd < (NUM_W'(RAD_DIV) << 1)))
      else $error("reciprocal quotient estimate off by more than one");
`endif

endmodule

### rtl/core/aarm_cordic.sv
// ----------------------------------------------------------------------------
// aarm_cordic
// Rotation-mode CORDIC, one micro-rotation per register stage.
// ----------------------------------------------------------------------------
module aarm_cordic
   import aarm_pkg::*;
#(
   parameter int unsigned STEPS = DEF_CORDIC_STEPS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  logic signed [CORDIC_W-1:0] in_theta,
   input  side_type                   in_side,
   output logic                       out_valid,
   output logic signed [CORDIC_W-1:0] out_cos,
   output logic signed [CORDIC_W-1:0] out_sin,
   output side_type                   out_side
);

   localparam int unsigned N = (STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : STEPS;

   logic [N-1:0]               v_ff;
   logic signed [CORDIC_W-1:0] x_ff [N];
   logic signed [CORDIC_W-1:0] y_ff [N];
   logic signed [CORDIC_W-1:0] z_ff [N];
   side_type                   side_ff [N];

   for (genvar i = 0; i < N; i++) begin : g_step
      localparam logic signed [CORDIC_W-1:0] ATAN = CORDIC_W'(atan_q30(i));
      logic signed [CORDIC_W-1:0] x_prev, y_prev, z_prev;
      logic signed [CORDIC_W-1:0] x_in, y_in, z_in;
      side_type                   side_prev;

      if (i == 0) begin : g_first
         assign x_prev    = CORDIC_GAIN;
         assign y_prev    = '0;
         assign z_prev    = in_theta;
         assign side_prev = in_side;
      end else begin : g_next
         assign x_prev    = x_ff[i-1];
         assign y_prev    = y_ff[i-1];
         assign z_prev    = z_ff[i-1];
         assign side_prev = side_ff[i-1];
      end

      always_comb begin
         if (!z_prev[CORDIC_W-1]) begin
            x_in = x_prev - (y_prev >>> i);
            y_in = y_prev + (x_prev >>> i);
            z_in = z_prev - ATAN;
         end else begin
            x_in = x_prev + (y_prev >>> i);
            y_in = y_prev - (x_prev >>> i);
            z_in = z_prev + ATAN;
         end
      end

      always_ff @(posedge clock) begin
         x_ff[i]    <= x_in;
         y_ff[i]    <= y_in;
         z_ff[i]    <= z_in;
         side_ff[i] <= side_prev;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[N-2:0], in_valid};
      end
   end

   assign out_valid = v_ff[N-1];
   assign out_cos   = x_ff[N-1];
   assign out_sin   = y_ff[N-1];
   assign out_side  = side_ff[N-1];

`ifndef SYNTH
   a_step_latency: assert property (@(posedge clock) disable iff (reset)
      v_ff[N-1] |-> $past(in_valid, N))
      else $error("rotation stage output without matching entry");
`endif

endmodule

### rtl/core/aarm_matrix.sv
// ----------------------------------------------------------------------------
// aarm_matrix
// Maps the quadrant, forms cos*I + (1-cos)*a*a^T + sin*[a]x and rounds and
// saturates the nine entries.
// ----------------------------------------------------------------------------
module aarm_matrix
   import aarm_pkg::*;
#(
   parameter int unsigned FRAC = DEF_FRACTION_BITS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  logic signed [CORDIC_W-1:0] in_cos,
   input  logic signed [CORDIC_W-1:0] in_sin,
   input  side_type                   in_side,
   output logic                       out_valid,
   output logic signed [FIELD_W-1:0]  out_m [9]
);

   localparam int unsigned OMC_W  = CORDIC_W - 1;
   localparam int unsigned AA_W   = 2 * FIELD_W;
   localparam int unsigned PROD_W = OMC_W + AA_W;
   localparam int unsigned SA_W   = CORDIC_W + FIELD_W;
   localparam int unsigned DIAG_W = CORDIC_W + FRAC;
   localparam int unsigned TERM_W = PROD_W - FRAC;
   localparam int unsigned MAX_A  = (DIAG_W > TERM_W) ? DIAG_W : TERM_W;
   localparam int unsigned MAX_B  = (MAX_A > SA_W) ? MAX_A : SA_W;
   localparam int unsigned SUM_W  = MAX_B + 2;
   localparam int unsigned RES_W  = SUM_W - ANGLE_FRAC;

   localparam int unsigned XX = 0;
   localparam int unsigned YY = 1;
   localparam int unsigned ZZ = 2;
   localparam int unsigned XY = 3;
   localparam int unsigned XZ = 4;
   localparam int unsigned YZ = 5;
   localparam int unsigned AX = 0;
   localparam int unsigned AY = 1;
   localparam int unsigned AZ = 2;

   localparam logic signed [RES_W-1:0] SAT_HI = RES_W'(32767);
   localparam logic signed [RES_W-1:0] SAT_LO = RES_W'(-32768);

   logic [MATRIX_PIPE-1:0] v_ff;

   logic signed [CORDIC_W-1:0] cos_in, sin_in, cos_ff, sin_ff;
   logic signed [CORDIC_W:0]   omc_full;
   logic signed [OMC_W-1:0]    omc_ff;
   logic signed [FIELD_W-1:0]  a_in [3];
   logic signed [FIELD_W-1:0]  a_ff [3];
   logic signed [AA_W-1:0]     aa_in [6];
   logic signed [AA_W-1:0]     aa_ff [6];

   logic signed [PROD_W-1:0]   p_in [6];
   logic signed [PROD_W-1:0]   p_ff [6];
   logic signed [SA_W-1:0]     sa_in [3];
   logic signed [SA_W-1:0]     sa_ff [3];
   logic signed [SUM_W-1:0]    diag_in, diag_ff, diag_b_ff;

   logic signed [PROD_W-1:0]   rnd [6];
   logic signed [SUM_W-1:0]    t_in [6];
   logic signed [SUM_W-1:0]    t_ff [6];
   logic signed [SUM_W-1:0]    sa_b_ff [3];

   logic signed [SUM_W-1:0]    e_in [9];
   logic signed [SUM_W-1:0]    e_ff [9];

   logic signed [SUM_W-1:0]    r_full [9];
   logic signed [RES_W-1:0]    r [9];
   logic signed [FIELD_W-1:0]  m_in [9];
   logic signed [FIELD_W-1:0]  m_ff [9];

   always_comb begin
      unique case (in_side.quad)
         2'd0: begin
            cos_in = in_cos;
            sin_in = in_sin;
         end
         2'd1: begin
            cos_in = -in_sin;
            sin_in = in_cos;
         end
         2'd2: begin
            cos_in = -in_cos;
            sin_in = -in_sin;
         end
         default: begin
            cos_in = in_sin;
            sin_in = -in_cos;
         end
      endcase
      omc_full  = (CORDIC_W+1)'(ONE_Q30) - (CORDIC_W+1)'(cos_in);
      a_in[AX]  = in_side.axis_x;
      a_in[AY]  = in_side.axis_y;
      a_in[AZ]  = in_side.axis_z;
      aa_in[XX] = AA_W'(a_in[AX]) * AA_W'(a_in[AX]);
      aa_in[YY] = AA_W'(a_in[AY]) * AA_W'(a_in[AY]);
      aa_in[ZZ] = AA_W'(a_in[AZ]) * AA_W'(a_in[AZ]);
      aa_in[XY] = AA_W'(a_in[AX]) * AA_W'(a_in[AY]);
      aa_in[XZ] = AA_W'(a_in[AX]) * AA_W'(a_in[AZ]);
      aa_in[YZ] = AA_W'(a_in[AY]) * AA_W'(a_in[AZ]);
   end

   always_comb begin
      for (int k = 0; k < 6; k++) begin
         p_in[k] = PROD_W'(omc_ff) * PROD_W'(aa_ff[k]);
      end
      for (int k = 0; k < 3; k++) begin
         sa_in[k] = SA_W'(sin_ff) * SA_W'(a_ff[k]);
      end
      diag_in = SUM_W'(cos_ff) <<< FRAC;
   end

   always_comb begin
      for (int k = 0; k < 6; k++) begin
         rnd[k]  = p_ff[k] + (PROD_W'(1) <<< (FRAC - 1));
         t_in[k] = SUM_W'(rnd[k] >>> FRAC);
      end
   end

   always_comb begin
      e_in[0] = diag_b_ff + t_ff[XX];
      e_in[1] = t_ff[XY] - sa_b_ff[AZ];
      e_in[2] = t_ff[XZ] + sa_b_ff[AY];
      e_in[3] = t_ff[XY] + sa_b_ff[AZ];
      e_in[4] = diag_b_ff + t_ff[YY];
      e_in[5] = t_ff[YZ] - sa_b_ff[AX];
      e_in[6] = t_ff[XZ] - sa_b_ff[AY];
      e_in[7] = t_ff[YZ] + sa_b_ff[AX];
      e_in[8] = diag_b_ff + t_ff[ZZ];
   end

   always_comb begin
      for (int k = 0; k < 9; k++) begin
         r_full[k] = (e_ff[k] + (SUM_W'(1) <<< (ANGLE_FRAC - 1))) >>> ANGLE_FRAC;
         r[k]      = RES_W'(r_full[k]);
         priority if (r[k] > SAT_HI) begin
            m_in[k] = FIELD_W'(SAT_HI);
         end else if (r[k] < SAT_LO) begin
            m_in[k] = FIELD_W'(SAT_LO);
         end else begin
            m_in[k] = FIELD_W'(r[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[MATRIX_PIPE-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      cos_ff    <= cos_in;
      sin_ff    <= sin_in;
      omc_ff    <= omc_full[OMC_W-1:0];
      a_ff      <= a_in;
      aa_ff     <= aa_in;
      p_ff      <= p_in;
      sa_ff     <= sa_in;
      diag_ff   <= diag_in;
      t_ff      <= t_in;
      diag_b_ff <= diag_ff;
      for (int k = 0; k < 3; k++) begin
         sa_b_ff[k] <= SUM_W'(sa_ff[k]);
      end
      e_ff      <= e_in;
      m_ff      <= m_in;
   end

   assign out_valid = v_ff[MATRIX_PIPE-1];
   assign out_m     = m_ff;

endmodule

### rtl/core/axis_angle_rotation_matrix.sv
// ----------------------------------------------------------------------------
// axis_angle_rotation_matrix
// Rodrigues rotation matrix from an angle in 1/64 degree and a Q2.14 axis.
//
// Input: a transfer happens at each rising edge with start high and busy
// low. busy stays low, so one item can be transferred every cycle. The angle
// may be any 16-bit value and is taken modulo one turn; the axis is used as
// given, without normalization.
// Output: rsp_valid is high for exactly one cycle per item with the nine
// saturated Q2.14 entries m00..m22 in row order. There is no back pressure:
// the receiver must take each result in the cycle it is shown.
// Pipeline: CORDIC_STEPS + 11 register stages (27 at the default of 16 steps,
// rotations capped at 24): 6 stages of angle reduction and radian conversion,
// one stage per CORDIC rotation, 5 stages of matrix arithmetic.
// Throughput: one item per cycle; results leave in transfer order.
// Reset: synchronous, clears all stage valid bits, so items in flight are
// dropped and no result follows reset until new items are transferred.
// ----------------------------------------------------------------------------
module axis_angle_rotation_matrix
   import aarm_pkg::*;
#(
   parameter int unsigned CORDIC_STEPS  = DEF_CORDIC_STEPS,
   parameter int unsigned FRACTION_BITS = DEF_FRACTION_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic signed [FIELD_W-1:0] req_angle_sixtyfourths,
   input  logic signed [FIELD_W-1:0] req_axis_x,
   input  logic signed [FIELD_W-1:0] req_axis_y,
   input  logic signed [FIELD_W-1:0] req_axis_z,
   output logic                      rsp_valid,
   output logic signed [FIELD_W-1:0] rsp_m00,
   output logic signed [FIELD_W-1:0] rsp_m01,
   output logic signed [FIELD_W-1:0] rsp_m02,
   output logic signed [FIELD_W-1:0] rsp_m10,
   output logic signed [FIELD_W-1:0] rsp_m11,
   output logic signed [FIELD_W-1:0] rsp_m12,
   output logic signed [FIELD_W-1:0] rsp_m20,
   output logic signed [FIELD_W-1:0] rsp_m21,
   output logic signed [FIELD_W-1:0] rsp_m22
);

   localparam int unsigned ROT_STAGES =
      (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
   localparam int unsigned LATENCY = ANGLE_PIPE + ROT_STAGES + MATRIX_PIPE;

   logic                       in_xfer;
   side_type                   in_side;
   logic                       ang_valid;
   logic signed [CORDIC_W-1:0] ang_theta;
   side_type                   ang_side;
   logic                       rot_valid;
   logic signed [CORDIC_W-1:0] rot_cos;
   logic signed [CORDIC_W-1:0] rot_sin;
   side_type                   rot_side;
   logic signed [FIELD_W-1:0]  mat_m [9];

   assign busy    = 1'b0;
   assign in_xfer = start & ~busy;
   assign in_side = '{quad: 2'd0, axis_x: req_axis_x, axis_y: req_axis_y,
                      axis_z: req_axis_z};

   aarm_angle u_angle (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_xfer),
      .in_angle  (req_angle_sixtyfourths),
      .in_side   (in_side),
      .out_valid (ang_valid),
      .out_theta (ang_theta),
      .out_side  (ang_side)
   );

   aarm_cordic #(
      .STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (ang_valid),
      .in_theta  (ang_theta),
      .in_side   (ang_side),
      .out_valid (rot_valid),
      .out_cos   (rot_cos),
      .out_sin   (rot_sin),
      .out_side  (rot_side)
   );

   aarm_matrix #(
      .FRAC (FRACTION_BITS)
   ) u_matrix (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rot_valid),
      .in_cos    (rot_cos),
      .in_sin    (rot_sin),
      .in_side   (rot_side),
      .out_valid (rsp_valid),
      .out_m     (mat_m)
   );

   assign rsp_m00 = mat_m[0];
   assign rsp_m01 = mat_m[1];
   assign rsp_m02 = mat_m[2];
   assign rsp_m10 = mat_m[3];
   assign rsp_m11 = mat_m[4];
   assign rsp_m12 = mat_m[5];
   assign rsp_m20 = mat_m[6];
   assign rsp_m21 = mat_m[7];
   assign rsp_m22 = mat_m[8];

`ifndef SYNTH
   a_result_follows_transfer: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(in_xfer, LATENCY))
      else $error("result strobe without a transfer at the pipeline latency");
`endif

endmodule

### sim/rotation_matrix_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rotation_matrix_checker
// Watches the request and response ports of the rotation matrix pipeline.
// Every accepted request is turned into the nine expected Q2.14 entries of
// its Rodrigues matrix. Each response strobe is compared entry by entry with
// the oldest matrix still outstanding.
// ----------------------------------------------------------------------------
module rotation_matrix_checker
   import aarm_pkg::*;
#(
   parameter int unsigned CORDIC_STEPS  = DEF_CORDIC_STEPS,
   parameter int unsigned FRACTION_BITS = DEF_FRACTION_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      busy,
   input  logic signed [FIELD_W-1:0] req_angle_sixtyfourths,
   input  logic signed [FIELD_W-1:0] req_axis_x,
   input  logic signed [FIELD_W-1:0] req_axis_y,
   input  logic signed [FIELD_W-1:0] req_axis_z,
   input  logic                      rsp_valid,
   input  logic signed [FIELD_W-1:0] rsp_m00,
   input  logic signed [FIELD_W-1:0] rsp_m01,
   input  logic signed [FIELD_W-1:0] rsp_m02,
   input  logic signed [FIELD_W-1:0] rsp_m10,
   input  logic signed [FIELD_W-1:0] rsp_m11,
   input  logic signed [FIELD_W-1:0] rsp_m12,
   input  logic signed [FIELD_W-1:0] rsp_m20,
   input  logic signed [FIELD_W-1:0] rsp_m21,
   input  logic signed [FIELD_W-1:0] rsp_m22,
   output int                        fail_count,
   output int                        pending,
   output int                        matrices_checked
);

   typedef logic [8:0][FIELD_W-1:0] matrix_type;

   localparam longint ONE_RAD_Q30 = 64'sd1073741824;
   localparam longint START_GAIN  = 64'sd652032874;
   localparam logic [95:0] RAD_NUM = 96'd31415926;
   localparam logic [95:0] RAD_DEN = 96'd115200000000;
   localparam int MAX_PRINTED = 100;

   matrix_type expected_mats [$];
   int         mismatches = 0;
   int         checked    = 0;

   function automatic longint atan_step(input int idx);
      longint val;
      case (idx)
         0:       val = 843314856;
         1:       val = 497837829;
         2:       val = 263043836;
         3:       val = 133525158;
         4:       val = 67021686;
         5:       val = 33543515;
         6:       val = 16775850;
         7:       val = 8388437;
         8:       val = 4194282;
         9:       val = 2097149;
         10:      val = 1048575;
         11:      val = 524287;
         12:      val = 262143;
         13:      val = 131071;
         14:      val = 65535;
         15:      val = 32767;
         16:      val = 16383;
         17:      val = 8191;
         18:      val = 4095;
         19:      val = 2047;
         20:      val = 1023;
         21:      val = 511;
         22:      val = 255;
         23:      val = 127;
         default: val = 0;
      endcase
      return val;
   endfunction

   function automatic matrix_type predict_rotation(
      input logic signed [FIELD_W-1:0] ang_in,
      input logic signed [FIELD_W-1:0] ax_in,
      input logic signed [FIELD_W-1:0] ay_in,
      input logic signed [FIELD_W-1:0] az_in
   );
      longint      ang, red, rem;
      longint      x, y, z, dx, dy;
      longint      cs, sn, omc, sum, term;
      longint      axis [3];
      longint      skew [3][3];
      logic [95:0] wide;
      int          quad, steps;
      matrix_type  mat;
      ang  = longint'(ang_in);
      red  = ((ang % TURN_UNITS) + TURN_UNITS) % TURN_UNITS;
      quad = int'(red / QUARTER_UNITS);
      rem  = red % QUARTER_UNITS;
      wide = 96'(rem);
      wide = ((wide * RAD_NUM) << 30) + (RAD_DEN >> 1);
      wide = wide / RAD_DEN;
      x = START_GAIN;
      y = 0;
      z = longint'(wide[63:0]);
      steps = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
      for (int i = 0; i < steps; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - atan_step(i);
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + atan_step(i);
         end
      end
      case (quad)
         0: begin
            cs = x;
            sn = y;
         end
         1: begin
            cs = -y;
            sn = x;
         end
         2: begin
            cs = -x;
            sn = -y;
         end
         default: begin
            cs = y;
            sn = -x;
         end
      endcase
      omc = ONE_RAD_Q30 - cs;
      axis[0] = longint'(ax_in);
      axis[1] = longint'(ay_in);
      axis[2] = longint'(az_in);
      skew[0][0] = 0;        skew[0][1] = -axis[2]; skew[0][2] = axis[1];
      skew[1][0] = axis[2];  skew[1][1] = 0;        skew[1][2] = -axis[0];
      skew[2][0] = -axis[1]; skew[2][1] = axis[0];  skew[2][2] = 0;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            sum  = (i == j) ? (cs <<< FRACTION_BITS) : 0;
            term = omc * (axis[i] * axis[j]);
            sum  = sum + ((term + (64'sd1 <<< (FRACTION_BITS - 1))) >>> FRACTION_BITS);
            sum  = sum + sn * skew[i][j];
            sum  = (sum + (64'sd1 <<< 29)) >>> 30;
            if (sum > 32767) begin
               sum = 32767;
            end else if (sum < -32768) begin
               sum = -32768;
            end
            mat[i * 3 + j] = sum[FIELD_W-1:0];
         end
      end
      return mat;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      if (mismatches < MAX_PRINTED) begin
         $display("%0t mismatch on matrix %0d, %s: got %0d, expected %0d",
                  $time, checked, what, got, want);
      end
      mismatches++;
   endtask

   always @(posedge clock) begin
      matrix_type got, want;
      if (reset) begin
         expected_mats.delete();
      end else begin
         if (rsp_valid) begin
            got = {rsp_m22, rsp_m21, rsp_m20, rsp_m12, rsp_m11, rsp_m10,
                   rsp_m02, rsp_m01, rsp_m00};
            if (expected_mats.size() == 0) begin
               report_mismatch("unexpected result", int'($signed(got[0])), 0);
            end else begin
               want = expected_mats.pop_front();
               for (int k = 0; k < 9; k++) begin
                  if (got[k] !== want[k]) begin
                     report_mismatch($sformatf("m%0d%0d", k / 3, k % 3),
                                     int'($signed(got[k])), int'($signed(want[k])));
                  end
               end
            end
            checked++;
         end
         if (start && !busy) begin
            expected_mats.push_back(predict_rotation(req_angle_sixtyfourths,
                                                     req_axis_x, req_axis_y,
                                                     req_axis_z));
         end
      end
      fail_count       <= mismatches;
      pending          <= expected_mats.size();
      matrices_checked <= checked;
   end

endmodule

### sim/axis_angle_rotation_matrix_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// axis_angle_rotation_matrix_tb
// Drives angle and axis requests into the rotation matrix pipeline: a
// directed set of quadrant boundaries, wrapped angles and extreme axes, then
// random unit and full-range axes with random gaps and back-to-back bursts.
// A checker beside the block predicts and compares every matrix.
// ----------------------------------------------------------------------------
module axis_angle_rotation_matrix_tb;
   import aarm_pkg::*;

   localparam int LATENCY      = DEF_CORDIC_STEPS + 11;
   localparam int RANDOM_ITEMS = 1750;

   logic                      clock;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic signed [FIELD_W-1:0] req_angle_sixtyfourths;
   logic signed [FIELD_W-1:0] req_axis_x;
   logic signed [FIELD_W-1:0] req_axis_y;
   logic signed [FIELD_W-1:0] req_axis_z;
   logic                      rsp_valid;
   logic signed [FIELD_W-1:0] rsp_m00, rsp_m01, rsp_m02;
   logic signed [FIELD_W-1:0] rsp_m10, rsp_m11, rsp_m12;
   logic signed [FIELD_W-1:0] rsp_m20, rsp_m21, rsp_m22;
   int                        fail_count;
   int                        pending;
   int                        matrices_checked;
   int                        items_sent;
   int                        burst_left;

   axis_angle_rotation_matrix uut (
      .clock                  (clock),
      .reset                  (reset),
      .start                  (start),
      .busy                   (busy),
      .req_angle_sixtyfourths (req_angle_sixtyfourths),
      .req_axis_x             (req_axis_x),
      .req_axis_y             (req_axis_y),
      .req_axis_z             (req_axis_z),
      .rsp_valid              (rsp_valid),
      .rsp_m00                (rsp_m00),
      .rsp_m01                (rsp_m01),
      .rsp_m02                (rsp_m02),
      .rsp_m10                (rsp_m10),
      .rsp_m11                (rsp_m11),
      .rsp_m12                (rsp_m12),
      .rsp_m20                (rsp_m20),
      .rsp_m21                (rsp_m21),
      .rsp_m22                (rsp_m22)
   );

   rotation_matrix_checker checker_i (
      .clock                  (clock),
      .reset                  (reset),
      .start                  (start),
      .busy                   (busy),
      .req_angle_sixtyfourths (req_angle_sixtyfourths),
      .req_axis_x             (req_axis_x),
      .req_axis_y             (req_axis_y),
      .req_axis_z             (req_axis_z),
      .rsp_valid              (rsp_valid),
      .rsp_m00                (rsp_m00),
      .rsp_m01                (rsp_m01),
      .rsp_m02                (rsp_m02),
      .rsp_m10                (rsp_m10),
      .rsp_m11                (rsp_m11),
      .rsp_m12                (rsp_m12),
      .rsp_m20                (rsp_m20),
      .rsp_m21                (rsp_m21),
      .rsp_m22                (rsp_m22),
      .fail_count             (fail_count),
      .pending                (pending),
      .matrices_checked       (matrices_checked)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("FAIL");
      $finish;
   end

   task automatic transfer_item(input logic signed [FIELD_W-1:0] ang,
                                input logic signed [FIELD_W-1:0] ax,
                                input logic signed [FIELD_W-1:0] ay,
                                input logic signed [FIELD_W-1:0] az);
      start                  <= 1'b1;
      req_angle_sixtyfourths <= ang;
      req_axis_x             <= ax;
      req_axis_y             <= ay;
      req_axis_z             <= az;
      @(posedge clock);
      while (busy) @(posedge clock);
      items_sent++;
   endtask

   // hold start low with junk on the fields
   task automatic idle_cycles(input int n);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) begin
            req_angle_sixtyfourths <= FIELD_W'($urandom);
            req_axis_x             <= FIELD_W'($urandom);
            req_axis_y             <= FIELD_W'($urandom);
            req_axis_z             <= FIELD_W'($urandom);
            @(posedge clock);
         end
      end
   endtask

   function automatic int pick_gap();
      int r;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         burst_left = $urandom_range(20, 80);
         return 0;
      end else if (r < 55) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   task automatic make_unit_axis(output logic signed [FIELD_W-1:0] ax,
                                 output logic signed [FIELD_W-1:0] ay,
                                 output logic signed [FIELD_W-1:0] az);
      real rx, ry, rz, norm;
      rx = $itor($urandom_range(0, 2000)) - 1000.0;
      ry = $itor($urandom_range(0, 2000)) - 1000.0;
      rz = $itor($urandom_range(0, 2000)) - 1000.0;
      norm = $sqrt(rx * rx + ry * ry + rz * rz);
      if (norm < 1.0) begin
         rx   = 1.0;
         norm = 1.0;
      end
      ax = FIELD_W'($rtoi(rx / norm * 16384.0));
      ay = FIELD_W'($rtoi(ry / norm * 16384.0));
      az = FIELD_W'($rtoi(rz / norm * 16384.0));
   endtask

   task automatic random_item();
      logic signed [FIELD_W-1:0] ang, ax, ay, az;
      int                        kind;
      kind = $urandom_range(0, 99);
      make_unit_axis(ax, ay, az);
      if (kind < 55) begin
         ang = FIELD_W'($urandom_range(0, 2 * TURN_UNITS) - TURN_UNITS);
      end else if (kind < 70) begin
         ang = FIELD_W'(($urandom_range(0, 8) - 4) * QUARTER_UNITS
                        + $urandom_range(0, 4) - 2);
         if ($urandom_range(0, 1) == 0) begin
            ax = '0;
            ay = '0;
            az = '0;
            case ($urandom_range(0, 2))
               0:       ax = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
               1:       ay = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
               default: az = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
            endcase
         end
      end else if (kind < 90) begin
         ang = FIELD_W'($urandom);
         ax  = FIELD_W'($urandom);
         ay  = FIELD_W'($urandom);
         az  = FIELD_W'($urandom);
      end else begin
         ang = FIELD_W'($urandom);
         ax  = FIELD_W'($urandom);
         ay  = FIELD_W'($urandom);
         az  = FIELD_W'($urandom);
         case ($urandom_range(0, 2))
            0:       ax = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            1:       ay = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            default: az = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
         endcase
      end
      transfer_item(ang, ax, ay, az);
   endtask

   initial begin
      int guard;
      items_sent             = 0;
      burst_left             = 0;
      reset                  = 1'b1;
      start                  = 1'b0;
      req_angle_sixtyfourths = '0;
      req_axis_x             = '0;
      req_axis_y             = '0;
      req_axis_z             = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // quadrant boundaries and wrap-around of the angle
      transfer_item(16'sd0,      16'sd16384, 16'sd0,      16'sd0);
      transfer_item(16'sd5760,   16'sd0,      16'sd16384, 16'sd0);
      transfer_item(16'sd11520,  16'sd0,      16'sd0,      16'sd16384);
      transfer_item(16'sd17280,  -16'sd16384, 16'sd0,     16'sd0);
      transfer_item(16'sd23040,  16'sd0,      -16'sd16384, 16'sd0);
      transfer_item(-16'sd23040, 16'sd0,      16'sd0,      -16'sd16384);
      transfer_item(16'sd5759,   16'sd9459,   16'sd9459,   16'sd9459);
      transfer_item(16'sd1,      16'sd9459,   -16'sd9459,  16'sd9459);
      transfer_item(-16'sd1,     16'sd16384,  16'sd0,      16'sd0);
      transfer_item(16'sd23039,  16'sd0,      16'sd0,      16'sd16384);
      transfer_item(-16'sd5760,  16'sd0,      16'sd0,      16'sd16384);
      transfer_item(-16'sd11521, 16'sd0,      16'sd16384,  16'sd0);
      idle_cycles(3);
      transfer_item(16'sh7FFF,   16'sd16384,  16'sd0,      16'sd0);
      transfer_item(16'sh8000,   16'sd0,      16'sd16384,  16'sd0);
      // axes far from unit length, saturating entries
      transfer_item(16'sd2880,   16'sh7FFF,   16'sh7FFF,   16'sh7FFF);
      transfer_item(16'sd8640,   16'sh8000,   16'sh8000,   16'sh8000);
      transfer_item(16'sd14400,  16'sh7FFF,   16'sh8000,   16'sh7FFF);
      transfer_item(-16'sd2880,  16'sh8000,   16'sh7FFF,   16'sh8000);
      transfer_item(16'sd4000,   16'sd0,      16'sd0,      16'sd0);
      transfer_item(16'sh7FFF,   16'sh7FFF,   16'sh7FFF,   16'sh7FFF);
      transfer_item(16'sh8000,   16'sh8000,   16'sh8000,   16'sh8000);
      transfer_item(16'sd20000,  -16'sd1,     16'sd1,      16'sh7FFF);
      idle_cycles(LATENCY + 5);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         idle_cycles(pick_gap());
         random_item();
      end
      start <= 1'b0;
      @(posedge clock);

      guard = 0;
      while (pending != 0 && guard < 20 * LATENCY) begin
         @(posedge clock);
         guard++;
      end
      repeat (2 * LATENCY) @(posedge clock);

      $display("transferred %0d requests, checked %0d matrices", items_sent,
               matrices_checked);
      $display("angles over all quadrants and wraps, unit, zero and extreme axes");
      if (pending != 0) begin
         $display("%0d expected matrices never arrived", pending);
      end
      if (fail_count == 0 && pending == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
